### hdl/svtb_pkg.sv
package svtb_pkg;

  // item kinds
  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_SPEED = 3'd2,
    KIND_RUN   = 3'd3,
    KIND_START = 3'd4,
    KIND_READ  = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BAD_ID = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  localparam int unsigned US_PER_SECOND = 1000000;
  localparam logic [23:0] SPEED_ONE     = 24'd65536;
  localparam logic [62:0] TOTAL_MAX     = {63{1'b1}};
  // floor(2^64 / 1e6), split into a low word and the upper 13 bits
  localparam logic [31:0] RECIP_LO      = 32'hF7A0_B5ED;
  localparam logic [12:0] RECIP_HI      = 13'h10C6;

  // one clock entry as held in the state memory
  typedef struct packed {
    logic [62:0] total;
    logic [15:0] frac;
    logic [23:0] speed;
    logic        run;
    logic        armed;
    logic [39:0] start;
    logic [43:0] now;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    total: 63'd0,
    frac:  16'd0,
    speed: SPEED_ONE,
    run:   1'b0,
    armed: 1'b0,
    start: 40'd0,
    now:   44'd0
  };

endpackage

### hdl/scaled_virtual_timer_bank.sv
// Scaled virtual timer bank.
//
// Holds up to TIMERS virtual clocks, each advancing at its own Q8.16 speed.
// Input: one transaction is taken at a rising edge with start high and busy
// low. kind selects tick, add clock, set speed, set running, set start or
// read; the other input ports carry the operands of that kind.
// Output: every transaction gives exactly one result, shown for one cycle
// with result_valid_o high. The receiver cannot stall, so nothing queues.
// Add clock, bad id, unused kind and tick with no clocks answer straight
// from idle. Set speed / running / start and read take a memory read, then
// the write back (read writes nothing). A tick visits the clocks in turn: a
// stopped clock needs only its read, an armed one its read and the disarm.
// A running clock takes the 32x24 product, then the fraction and saturating
// total add, then total / 1e6: four partial products of the total's words
// against the reciprocal, then the remainder, then the correction and
// write back.
// busy stays high from acceptance until the result strobe of a tick over a
// nonempty table and of a set or read with a valid id; others leave busy low.
// Reset empties the table (clock count zero); entries are initialized when
// a clock is added, so the state memory needs no clearing pass.
module scaled_virtual_timer_bank #(
  parameter int unsigned TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  timer_id_i,
  input  logic [31:0] elapsed_us_i,
  input  logic [23:0] speed_value_i,
  input  logic        run_flag_i,
  input  logic [39:0] start_second_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [7:0]  clock_id_o,
  output logic [62:0] total_us_o,
  output logic [43:0] unix_now_o,
  output logic [39:0] unix_begin_o,
  output logic [23:0] speed_now_o,
  output logic        running_o
);

  localparam int unsigned IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;  // entry index
  localparam int unsigned CW = $clog2(TIMERS + 1);                 // clock count

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RMW    = 3'd1;  // read data of addressed clock ready
  localparam logic [2:0] ST_TK_RD  = 3'd2;  // read data of tick entry ready
  localparam logic [2:0] ST_TK_ACC = 3'd3;  // fraction and total update
  localparam logic [2:0] ST_TK_DIV = 3'd4;  // total / 1e6 by reciprocal

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [2:0]          kind_q, kind_d;
  logic [IW-1:0]       id_q, id_d;
  logic [31:0]         elapsed_q, elapsed_d;
  logic [23:0]         speed_q, speed_d;
  logic                run_q, run_d;
  logic [39:0]         start_q, start_d;
  logic [IW-1:0]       idx_q, idx_d;
  svtb_pkg::entry_t    ent_q, ent_d;
  logic [55:0]         prod_q, prod_d;
  logic [21:0]         rem_q, rem_d;
  logic [63:0]         mq_q, mq_d;
  logic [2:0]          step_q, step_d;

  // result registers
  logic                rv_q, rv_d;
  logic [1:0]          rs_q, rs_d;
  logic [7:0]          rid_q, rid_d;
  svtb_pkg::entry_t    rent_q, rent_d;

  // state memory, one entry per clock
  svtb_pkg::entry_t    mem [0:TIMERS-1];
  svtb_pkg::entry_t    rdata_q;
  logic                mem_re, mem_we;
  logic [IW-1:0]       mem_raddr, mem_waddr;
  svtb_pkg::entry_t    mem_wdata;

  logic                advance;  // tick entry done, move to the next one
  logic                last_entry;
  logic [IW-1:0]       idx_nx;

  assign busy       = (state_q != ST_IDLE);
  assign idx_nx     = idx_q + IW'(1);
  assign last_entry = ((CW'(idx_q) + CW'(1)) == count_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    svtb_pkg::entry_t upd;
    logic [56:0]      acc;
    logic [63:0]      sum;
    logic [62:0]      new_total;
    logic [63:0]      part;
    logic [21:0]      low_prod;
    logic [43:0]      quot;

    state_d   = state_q;
    count_d   = count_q;
    kind_d    = kind_q;
    id_d      = id_q;
    elapsed_d = elapsed_q;
    speed_d   = speed_q;
    run_d     = run_q;
    start_d   = start_q;
    idx_d     = idx_q;
    ent_d     = ent_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    mq_d      = mq_q;
    step_d    = step_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = ent_q;
    rv_d      = 1'b0;
    rs_d      = svtb_pkg::STATUS_OK;
    rid_d     = 8'd0;
    rent_d    = '0;
    advance   = 1'b0;
    upd       = rdata_q;
    acc       = '0;
    sum       = '0;
    new_total = '0;
    part      = '0;
    low_prod  = '0;
    quot      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d    = kind_i;
          id_d      = timer_id_i[IW-1:0];
          elapsed_d = elapsed_us_i;
          speed_d   = speed_value_i;
          run_d     = run_flag_i;
          start_d   = start_second_i;
          unique case (svtb_pkg::kind_e'(kind_i))
            svtb_pkg::KIND_TICK: begin
              if (count_q == '0) begin
                rv_d = 1'b1;
              end else begin
                idx_d     = '0;
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_TK_RD;
              end
            end
            svtb_pkg::KIND_ADD: begin
              rv_d = 1'b1;
              if (count_q == CW'(TIMERS)) begin
                rs_d = svtb_pkg::STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IW-1:0];
                mem_wdata = svtb_pkg::ENTRY_RESET;
                count_d   = count_q + CW'(1);
                rid_d     = 8'(count_q);
                rent_d    = svtb_pkg::ENTRY_RESET;
              end
            end
            svtb_pkg::KIND_SPEED, svtb_pkg::KIND_RUN,
            svtb_pkg::KIND_START, svtb_pkg::KIND_READ: begin
              if ({1'b0, timer_id_i} >= 9'(count_q)) begin
                rv_d = 1'b1;
                rs_d = svtb_pkg::STATUS_BAD_ID;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = timer_id_i[IW-1:0];
                state_d   = ST_RMW;
              end
            end
            default: begin
              rv_d = 1'b1;  // unused kinds: ok, all zero
            end
          endcase
        end
      end

      ST_RMW: begin
        unique case (svtb_pkg::kind_e'(kind_q))
          svtb_pkg::KIND_SPEED: upd.speed = speed_q;
          svtb_pkg::KIND_RUN: begin
            if (run_q && !rdata_q.run) begin
              upd.armed = 1'b1;
            end
            if (!run_q) begin
              upd.armed = 1'b0;
            end
            upd.run = run_q;
          end
          svtb_pkg::KIND_START: upd.start = start_q;
          default: ;
        endcase
        mem_we    = (kind_q != 3'(svtb_pkg::KIND_READ));
        mem_waddr = id_q;
        mem_wdata = upd;
        rv_d      = 1'b1;
        rid_d     = 8'(id_q);
        rent_d    = upd;
        state_d   = ST_IDLE;
      end

      ST_TK_RD: begin
        if (!rdata_q.run) begin
          advance = 1'b1;
        end else if (rdata_q.armed) begin
          // freshly started: this tick only disarms
          upd.armed = 1'b0;
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = upd;
          advance   = 1'b1;
        end else begin
          ent_d   = rdata_q;
          prod_d  = 56'(elapsed_q) * 56'(rdata_q.speed);
          state_d = ST_TK_ACC;
        end
      end

      ST_TK_ACC: begin
        acc       = {1'b0, prod_q} + 57'(ent_q.frac);
        sum       = {1'b0, ent_q.total} + 64'(acc[56:16]);
        new_total = sum[63] ? svtb_pkg::TOTAL_MAX : sum[62:0];
        ent_d.frac  = acc[15:0];
        ent_d.total = new_total;
        step_d  = '0;
        state_d = ST_TK_DIV;
      end

      ST_TK_DIV: begin
        // q0 = floor(total * RECIP / 2^64) is the quotient or one below it
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: begin
            part = 64'(ent_q.total[31:0]) * 64'(svtb_pkg::RECIP_LO);
            mq_d = {32'd0, part[63:32]};
          end
          3'd1: mq_d = mq_q + 64'(ent_q.total[31:0]) * 64'(svtb_pkg::RECIP_HI);
          3'd2: mq_d = mq_q + 64'(ent_q.total[62:32]) * 64'(svtb_pkg::RECIP_LO);
          3'd3: begin
            mq_d = {32'd0, mq_q[63:32]} +
                   64'(ent_q.total[62:32]) * 64'(svtb_pkg::RECIP_HI);
          end
          3'd4: begin
            // remainder stays below 2e6, so 22 low bits hold it exactly
            low_prod = mq_q[21:0] * 22'(svtb_pkg::US_PER_SECOND);
            rem_d    = ent_q.total[21:0] - low_prod;
          end
          3'd5: begin
            quot      = mq_q[43:0] + 44'(rem_q >= 22'(svtb_pkg::US_PER_SECOND));
            upd       = ent_q;
            upd.now   = 44'(ent_q.start) + quot;
            mem_we    = 1'b1;
            mem_waddr = idx_q;
            mem_wdata = upd;
            advance   = 1'b1;
          end
          default: ;
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (last_entry) begin
        rv_d    = 1'b1;  // tick result is ok, all zero
        state_d = ST_IDLE;
      end else begin
        idx_d     = idx_nx;
        mem_re    = 1'b1;
        mem_raddr = idx_nx;
        state_d   = ST_TK_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    id_q      <= id_d;
    elapsed_q <= elapsed_d;
    speed_q   <= speed_d;
    run_q     <= run_d;
    start_q   <= start_d;
    idx_q     <= idx_d;
    ent_q     <= ent_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    mq_q      <= mq_d;
    step_q    <= step_d;
    rs_q      <= rs_d;
    rid_q     <= rid_d;
    rent_q    <= rent_d;
  end

  assign result_valid_o = rv_q;
  assign status_o       = rs_q;
  assign clock_id_o     = rid_q;
  assign total_us_o     = rent_q.total;
  assign unix_now_o     = rent_q.now;
  assign unix_begin_o   = rent_q.start;
  assign speed_now_o    = rent_q.speed;
  assign running_o      = rent_q.run;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TIMERS))
    else $error("clock count beyond table size");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != 2'(svtb_pkg::STATUS_OK)) |->
      (clock_id_o == 8'd0 && total_us_o == '0 && speed_now_o == '0 && !running_o))
    else $error("error result carries nonzero fields");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == 3'(svtb_pkg::KIND_TICK) && count_q != '0) |=> busy)
    else $error("tick over a nonempty table did not go busy");
`endif

endmodule

### verif/testbench.sv
module testbench;

  localparam int unsigned NUM_TIMERS   = 16;
  localparam int unsigned NUM_RANDOM   = 1280;
  // slowest transaction is a tick over sixteen running clocks
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 50;

  // kinds the block decodes as no-ops
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;
  localparam logic [23:0] SPEED_MAX   = 24'hFF_FFFF;
  localparam logic [39:0] SECOND_MAX  = 40'hFF_FFFF_FFFF;

  // one result transaction, field order matches the output ports
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  clock_id;
    logic [62:0] total_us;
    logic [43:0] unix_now;
    logic [39:0] unix_begin;
    logic [23:0] speed_now;
    logic        running;
  } readout_t;

  // Mirror of the clock table plus the queue of readouts still owed by the DUT.
  class clock_table_sb;
    int unsigned entries_used;
    logic [62:0] tot_us  [NUM_TIMERS];
    logic [15:0] frac_q  [NUM_TIMERS];
    logic [23:0] rate_q  [NUM_TIMERS];
    logic        on_q    [NUM_TIMERS];
    logic        armed_q [NUM_TIMERS];
    logic [39:0] epoch_q [NUM_TIMERS];
    logic [43:0] now_q   [NUM_TIMERS];
    readout_t    owed[$];
    int unsigned errors;

    function readout_t snapshot(int unsigned i);
      readout_t r;
      r.status     = svtb_pkg::STATUS_OK;
      r.clock_id   = 8'(i);
      r.total_us   = tot_us[i];
      r.unix_now   = now_q[i];
      r.unix_begin = epoch_q[i];
      r.speed_now  = rate_q[i];
      r.running    = on_q[i];
      return r;
    endfunction

    // Advance every running clock; a freshly started clock only drops its arm.
    function void advance_clocks(logic [31:0] elapsed);
      logic [63:0] acc;
      logic [63:0] whole;
      for (int unsigned i = 0; i < entries_used; i++) begin
        if (!on_q[i]) continue;
        if (armed_q[i]) begin
          armed_q[i] = 1'b0;
          continue;
        end
        acc = {48'd0, frac_q[i]} + {32'd0, elapsed} * {40'd0, rate_q[i]};
        whole = {16'd0, acc[63:16]};
        frac_q[i] = acc[15:0];
        if (whole > {1'b0, svtb_pkg::TOTAL_MAX} - {1'b0, tot_us[i]})
          tot_us[i] = svtb_pkg::TOTAL_MAX;
        else
          tot_us[i] = tot_us[i] + whole[62:0];
        now_q[i] = 44'({24'd0, epoch_q[i]} + {1'b0, tot_us[i]} / 64'd1000000);
      end
    endfunction

    function void log_command(logic [2:0] kind, logic [7:0] id, logic [31:0] elapsed,
                              logic [23:0] speed, logic run, logic [39:0] second);
      readout_t r;
      r = '0;
      r.status = svtb_pkg::STATUS_OK;
      if (kind == svtb_pkg::KIND_TICK) begin
        advance_clocks(elapsed);
      end else if (kind == svtb_pkg::KIND_ADD) begin
        if (entries_used >= NUM_TIMERS) begin
          r.status = svtb_pkg::STATUS_FULL;
        end else begin
          tot_us[entries_used]  = '0;
          frac_q[entries_used]  = '0;
          rate_q[entries_used]  = svtb_pkg::SPEED_ONE;
          on_q[entries_used]    = 1'b0;
          armed_q[entries_used] = 1'b0;
          epoch_q[entries_used] = '0;
          now_q[entries_used]   = '0;
          entries_used++;
          r = snapshot(entries_used - 1);
        end
      end else if (kind > svtb_pkg::KIND_READ) begin
        // unused kind: all-zero readout
      end else if (id >= entries_used) begin
        r.status = svtb_pkg::STATUS_BAD_ID;
      end else begin
        case (kind)
          svtb_pkg::KIND_SPEED: rate_q[id] = speed;
          svtb_pkg::KIND_RUN: begin
            // start from stopped arms; stop always disarms
            if (run && !on_q[id]) armed_q[id] = 1'b1;
            if (!run) armed_q[id] = 1'b0;
            on_q[id] = run;
          end
          svtb_pkg::KIND_START: epoch_q[id] = second;
          default: ;
        endcase
        r = snapshot(id);
      end
      owed = {owed, r};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_readout(readout_t got);
      readout_t want;
      if (owed.size() == 0) begin
        $error("result strobe with no transaction outstanding (status %0d)", got.status);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("clock_id", 64'(want.clock_id), 64'(got.clock_id));
      compare_field("total_us", 64'(want.total_us), 64'(got.total_us));
      compare_field("unix_now", 64'(want.unix_now), 64'(got.unix_now));
      compare_field("unix_begin", 64'(want.unix_begin), 64'(got.unix_begin));
      compare_field("speed_now", 64'(want.speed_now), 64'(got.speed_now));
      compare_field("running", 64'(want.running), 64'(got.running));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind_i = '0;
  logic [7:0]  timer_id_i = '0;
  logic [31:0] elapsed_us_i = '0;
  logic [23:0] speed_value_i = '0;
  logic        run_flag_i = 1'b0;
  logic [39:0] start_second_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [7:0]  clock_id_o;
  logic [62:0] total_us_o;
  logic [43:0] unix_now_o;
  logic [39:0] unix_begin_o;
  logic [23:0] speed_now_o;
  logic        running_o;

  clock_table_sb sb = new;
  int unsigned   added = 0;       // clocks the driver has asked for, capped at the table size
  int unsigned   stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  scaled_virtual_timer_bank #(.TIMERS(NUM_TIMERS)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .timer_id_i     (timer_id_i),
    .elapsed_us_i   (elapsed_us_i),
    .speed_value_i  (speed_value_i),
    .run_flag_i     (run_flag_i),
    .start_second_i (start_second_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .clock_id_o     (clock_id_o),
    .total_us_o     (total_us_o),
    .unix_now_o     (unix_now_o),
    .unix_begin_o   (unix_begin_o),
    .speed_now_o    (speed_now_o),
    .running_o      (running_o)
  );

  // Monitor: pre-edge values at the rising edge. The result is checked before
  // the new command is logged, since it always belongs to an older transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        sb.check_readout({status_o, clock_id_o, total_us_o, unix_now_o, unix_begin_o,
                          speed_now_o, running_o});
      if (start && !busy)
        sb.log_command(kind_i, timer_id_i, elapsed_us_i, speed_value_i, run_flag_i,
                       start_second_i);
    end
  end

  // Watchdog on cycles with no transaction in either direction.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Drive one command from the falling edge and hold it until it is taken.
  task automatic send_txn(input logic [2:0] kind, input logic [7:0] id,
                          input logic [31:0] elapsed, input logic [23:0] speed,
                          input logic run, input logic [39:0] second);
    @(negedge clk_i);
    start          <= 1'b1;
    kind_i         <= kind;
    timer_id_i     <= id;
    elapsed_us_i   <= elapsed;
    speed_value_i  <= speed;
    run_flag_i     <= run;
    start_second_i <= second;
    do @(posedge clk_i); while (busy);
    if (kind == svtb_pkg::KIND_ADD && added < NUM_TIMERS) added++;
  endtask

  // Sender gap; operand ports carry junk while start is low.
  task automatic pause(input int unsigned cycles);
    @(negedge clk_i);
    start         <= 1'b0;
    kind_i        <= 3'($urandom);
    timer_id_i    <= 8'($urandom);
    elapsed_us_i  <= $urandom;
    speed_value_i <= 24'($urandom);
    run_flag_i    <= 1'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  initial begin
    logic [2:0]  kind;
    logic [7:0]  id;
    logic [31:0] elapsed;
    logic [23:0] speed;
    logic        run;
    logic [39:0] second;
    int unsigned pick;
    int unsigned burst_left;

    burst_left = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // empty table: tick with no clocks, bad ids for every addressed kind
    send_txn(svtb_pkg::KIND_TICK, 8'd0, 32'd1000, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_READ, 8'd0, '0, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_SPEED, 8'd255, '0, SPEED_MAX, 1'b1, '0);
    send_txn(svtb_pkg::KIND_RUN, 8'd0, '0, '0, 1'b1, '0);
    send_txn(svtb_pkg::KIND_START, 8'd0, '0, '0, 1'b0, SECOND_MAX);
    // unused kinds with every operand bit set
    send_txn(KIND_SPARE_LO, 8'hFF, ELAPSED_MAX, SPEED_MAX, 1'b1, SECOND_MAX);
    send_txn(KIND_SPARE_HI, 8'hFF, ELAPSED_MAX, SPEED_MAX, 1'b1, SECOND_MAX);
    send_txn(svtb_pkg::KIND_ADD, '0, '0, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_ADD, '0, '0, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_ADD, '0, '0, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_READ, 8'd0, '0, '0, 1'b0, '0);
    // start clock 0: the first tick only disarms it
    send_txn(svtb_pkg::KIND_RUN, 8'd0, '0, '0, 1'b1, '0);
    send_txn(svtb_pkg::KIND_TICK, '0, 32'd500, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_TICK, '0, 32'd1000000, '0, 1'b0, '0);
    // run on a running clock must not re-arm
    send_txn(svtb_pkg::KIND_RUN, 8'd0, '0, '0, 1'b1, '0);
    // clock 1 at top speed and latest start second
    send_txn(svtb_pkg::KIND_SPEED, 8'd1, '0, SPEED_MAX, 1'b0, '0);
    send_txn(svtb_pkg::KIND_START, 8'd1, '0, '0, 1'b0, SECOND_MAX);
    send_txn(svtb_pkg::KIND_RUN, 8'd1, '0, '0, 1'b1, '0);
    send_txn(svtb_pkg::KIND_TICK, '0, 32'd0, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_TICK, '0, ELAPSED_MAX, '0, 1'b0, '0);
    // clock 2 at zero speed
    send_txn(svtb_pkg::KIND_SPEED, 8'd2, '0, 24'd0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_RUN, 8'd2, '0, '0, 1'b1, '0);
    send_txn(svtb_pkg::KIND_TICK, '0, 32'd12345, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_RUN, 8'd0, '0, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_READ, 8'd1, '0, '0, 1'b0, '0);
    send_txn(svtb_pkg::KIND_READ, 8'd2, '0, '0, 1'b0, '0);

    // --- random ---
    // Mostly valid ids so commands land on live clocks; adds are rare so the
    // table fills part way through and full-table adds follow.
    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(99);
      if (pick < 26)      kind = svtb_pkg::KIND_TICK;
      else if (pick < 46) kind = svtb_pkg::KIND_READ;
      else if (pick < 59) kind = svtb_pkg::KIND_SPEED;
      else if (pick < 78) kind = svtb_pkg::KIND_RUN;
      else if (pick < 90) kind = svtb_pkg::KIND_START;
      else if (pick < 94) kind = svtb_pkg::KIND_ADD;
      else                kind = $urandom_range(1) ? KIND_SPARE_LO : KIND_SPARE_HI;

      if (added > 0 && $urandom_range(9) < 8) id = 8'($urandom_range(added - 1));
      else if ($urandom_range(1)) id = 8'(added);
      else id = 8'($urandom_range(255));

      case ($urandom_range(9))
        0:       elapsed = 32'd0;
        1:       elapsed = ELAPSED_MAX;
        2, 3:    elapsed = $urandom;
        default: elapsed = $urandom_range(200000);
      endcase

      case ($urandom_range(7))
        0:       speed = 24'd0;
        1:       speed = svtb_pkg::SPEED_ONE;
        2:       speed = SPEED_MAX;
        3, 4:    speed = 24'($urandom);
        default: speed = 24'($urandom_range(131072, 32768));
      endcase

      case ($urandom_range(7))
        0:       second = '0;
        1:       second = SECOND_MAX;
        default: second = 40'({$urandom, $urandom});
      endcase

      run = ($urandom_range(3) != 0);
      send_txn(kind, id, elapsed, speed, run, second);

      // sender pacing: back-to-back, short gaps, long gaps, gap-free bursts
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        pick = $urandom_range(99);
        if (pick < 5)       burst_left = $urandom_range(60, 20);
        else if (pick < 55) ;
        else if (pick < 90) pause($urandom_range(3, 1));
        else                pause($urandom_range(60, 8));
      end
    end

    // drop start so the last command is not taken twice
    @(negedge clk_i);
    start <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.owed.size() != 0) begin
      $error("%0d results never arrived", sb.owed.size());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/svtb_pkg.sv
hdl/scaled_virtual_timer_bank.sv
verif/testbench.sv
